// File: rtl/core/i2cts_pkg.sv
// Package for the I2C transfer sequencer: operation, bus event and byte action
// codes, busy flag masks, and the item and result structs.
// No dependencies.
package i2cts_pkg;

    typedef enum logic [2:0] {
        OP_MASTER_WRITE = 3'd0,
        OP_MASTER_READ  = 3'd1,
        OP_SLAVE_TX     = 3'd2,
        OP_SLAVE_RX     = 3'd3,
        OP_BUS_EVENT    = 3'd4,
        OP_STOP         = 3'd5
    } op_t;

    typedef enum logic [4:0] {
        EV_BUS_ERROR     = 5'd0,
        EV_START         = 5'd1,
        EV_REP_START     = 5'd2,
        EV_SLAW_ACK      = 5'd3,
        EV_SLAW_NACK     = 5'd4,
        EV_MTX_ACK       = 5'd5,
        EV_MTX_NACK      = 5'd6,
        EV_ARB_LOST      = 5'd7,
        EV_SLAR_ACK      = 5'd8,
        EV_SLAR_NACK     = 5'd9,
        EV_MRX_ACK       = 5'd10,
        EV_MRX_NACK      = 5'd11,
        EV_OWN_SLAW      = 5'd12,
        EV_ARB_OWN_SLAW  = 5'd13,
        EV_GCALL         = 5'd14,
        EV_ARB_GCALL     = 5'd15,
        EV_SRX_ACK       = 5'd16,
        EV_SRX_NACK      = 5'd17,
        EV_GC_DATA_ACK   = 5'd18,
        EV_GC_DATA_NACK  = 5'd19,
        EV_SLAVE_STOP    = 5'd20,
        EV_OWN_SLAR      = 5'd21,
        EV_ARB_OWN_SLAR  = 5'd22,
        EV_STX_ACK       = 5'd23,
        EV_STX_NACK      = 5'd24,
        EV_STX_LAST      = 5'd25,
        EV_NONE          = 5'd26
    } bus_event_t;

    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_ADDR = 3'd1,
        ACT_MTX  = 3'd2,
        ACT_STX  = 3'd3,
        ACT_MRX  = 3'd4,
        ACT_SRX  = 3'd5
    } action_t;

    localparam logic [3:0] BUSY_MT = 4'b0001;
    localparam logic [3:0] BUSY_MR = 4'b0010;
    localparam logic [3:0] BUSY_ST = 4'b0100;
    localparam logic [3:0] BUSY_SR = 4'b1000;

    localparam logic RW_READ  = 1'b1;
    localparam logic RW_WRITE = 1'b0;

    typedef struct packed {
        logic [2:0] operation;
        logic [4:0] bus_event;
        logic [6:0] slave_address;
        logic [7:0] byte_count;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic       request_ok;
        logic       start_bit;
        logic       stop_bit;
        logic       ack_bit;
        logic [2:0] byte_action;
        logic [7:0] address_byte;
        logic [7:0] buffer_index;
        logic [7:0] stored_byte;
        logic [3:0] busy_flags;
    } result_t;

endpackage

// File: rtl/core/i2cts_if.sv
// Channel interfaces of the I2C transfer sequencer: request items in,
// result items out, each with valid/ready. No dependencies.
interface i2cts_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [4:0] bus_event;
    logic [6:0] slave_address;
    logic [7:0] byte_count;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output bus_event,
                    output slave_address, output byte_count, output rx_byte,
                    input ready);
    modport sink   (input valid, input operation, input bus_event,
                    input slave_address, input byte_count, input rx_byte,
                    output ready);
endinterface

interface i2cts_rsp_if;
    logic       valid;
    logic       ready;
    logic       request_ok;
    logic       start_bit;
    logic       stop_bit;
    logic       ack_bit;
    logic [2:0] byte_action;
    logic [7:0] address_byte;
    logic [7:0] buffer_index;
    logic [7:0] stored_byte;
    logic [3:0] busy_flags;

    modport source (output valid, output request_ok, output start_bit,
                    output stop_bit, output ack_bit, output byte_action,
                    output address_byte, output buffer_index,
                    output stored_byte, output busy_flags, input ready);
    modport sink   (input valid, input request_ok, input start_bit,
                    input stop_bit, input ack_bit, input byte_action,
                    input address_byte, input buffer_index,
                    input stored_byte, input busy_flags, output ready);
endinterface

// File: rtl/core/i2cts_engine.sv
// Sequencer state and per-item decision logic. Result is combinational from
// the registered item and current state; state commits on advance.
// Depends on i2cts_pkg.
module i2cts_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  i2cts_pkg::item_t  item,
    output i2cts_pkg::result_t result
);

    logic [7:0] byte_index_reg,     byte_index_next;
    logic [7:0] addr_rw_byte_reg,   addr_rw_byte_next;
    logic [7:0] master_tx_size_reg, master_tx_size_next;
    logic [7:0] master_rx_size_reg, master_rx_size_next;
    logic [7:0] slave_tx_size_reg,  slave_tx_size_next;
    logic [7:0] slave_rx_size_reg,  slave_rx_size_next;
    logic [3:0] mode_busy_reg,      mode_busy_next;
    logic       slave_armed_reg,    slave_armed_next;
    logic       start_reg,          start_next;
    logic       stop_reg,           stop_next;
    logic       ack_reg,            ack_next;

    logic [7:0] index_inc;
    logic       ok;
    logic [2:0] act;
    logic [7:0] addr;
    logic [7:0] idx;
    logic [7:0] stored;

    assign index_inc = byte_index_reg + 8'd1;

    always_comb
    begin
        byte_index_next     = byte_index_reg;
        addr_rw_byte_next   = addr_rw_byte_reg;
        master_tx_size_next = master_tx_size_reg;
        master_rx_size_next = master_rx_size_reg;
        slave_tx_size_next  = slave_tx_size_reg;
        slave_rx_size_next  = slave_rx_size_reg;
        mode_busy_next      = mode_busy_reg;
        slave_armed_next    = slave_armed_reg;
        start_next          = start_reg;
        stop_next           = stop_reg;
        ack_next            = ack_reg;
        ok                  = 1'b0;
        act                 = i2cts_pkg::ACT_NONE;
        addr                = 8'd0;
        idx                 = 8'd0;
        stored              = 8'd0;

        unique case (item.operation) inside
            i2cts_pkg::OP_MASTER_WRITE, i2cts_pkg::OP_MASTER_READ:
            begin
                if ((mode_busy_reg & (i2cts_pkg::BUSY_MT | i2cts_pkg::BUSY_MR)) == 4'd0)
                begin
                    if (item.operation == i2cts_pkg::OP_MASTER_WRITE)
                    begin
                        mode_busy_next      = mode_busy_reg | i2cts_pkg::BUSY_MT;
                        master_tx_size_next = item.byte_count;
                        addr_rw_byte_next   = {item.slave_address, i2cts_pkg::RW_WRITE};
                    end
                    else
                    begin
                        mode_busy_next      = mode_busy_reg | i2cts_pkg::BUSY_MR;
                        master_rx_size_next = item.byte_count;
                        addr_rw_byte_next   = {item.slave_address, i2cts_pkg::RW_READ};
                    end
                    stop_next  = 1'b0;
                    start_next = 1'b1;
                    ok         = 1'b1;
                end
            end
            i2cts_pkg::OP_SLAVE_TX:
            begin
                if ((mode_busy_reg & i2cts_pkg::BUSY_ST) == 4'd0)
                begin
                    mode_busy_next     = mode_busy_reg | i2cts_pkg::BUSY_ST;
                    slave_armed_next   = 1'b1;
                    slave_tx_size_next = item.byte_count;
                    ack_next           = 1'b1;
                    ok                 = 1'b1;
                end
            end
            i2cts_pkg::OP_SLAVE_RX:
            begin
                if ((mode_busy_reg & i2cts_pkg::BUSY_SR) == 4'd0)
                begin
                    mode_busy_next     = mode_busy_reg | i2cts_pkg::BUSY_SR;
                    slave_armed_next   = 1'b1;
                    slave_rx_size_next = item.byte_count;
                    ack_next           = 1'b1;
                    ok                 = 1'b1;
                end
            end
            i2cts_pkg::OP_STOP:
            begin
                stop_next = 1'b1;
                ok        = 1'b1;
            end
            i2cts_pkg::OP_BUS_EVENT:
            begin
                unique case (item.bus_event) inside
                    i2cts_pkg::EV_BUS_ERROR:
                    begin
                        start_next = 1'b0;
                        stop_next  = 1'b1;
                        ack_next   = 1'b0;
                    end
                    i2cts_pkg::EV_START, i2cts_pkg::EV_REP_START:
                    begin
                        byte_index_next = 8'd0;
                        act             = i2cts_pkg::ACT_ADDR;
                        addr            = addr_rw_byte_reg;
                        start_next      = 1'b0;
                    end
                    i2cts_pkg::EV_SLAW_ACK:
                    begin
                        act = i2cts_pkg::ACT_MTX;
                        idx = byte_index_reg;
                    end
                    i2cts_pkg::EV_MTX_ACK:
                    begin
                        byte_index_next = index_inc;
                        if (index_inc < master_tx_size_reg)
                        begin
                            act = i2cts_pkg::ACT_MTX;
                            idx = index_inc;
                        end
                        else
                        begin
                            stop_next      = 1'b1;
                            mode_busy_next = mode_busy_reg & ~i2cts_pkg::BUSY_MT;
                        end
                    end
                    i2cts_pkg::EV_SLAW_NACK, i2cts_pkg::EV_MTX_NACK:
                    begin
                        stop_next      = 1'b1;
                        mode_busy_next = mode_busy_reg & ~i2cts_pkg::BUSY_MT;
                    end
                    i2cts_pkg::EV_ARB_LOST:
                    begin
                        mode_busy_next = mode_busy_reg & ~i2cts_pkg::BUSY_MT;
                    end
                    i2cts_pkg::EV_SLAR_ACK:
                    begin
                        // single-byte read: nack the only byte
                        if (master_rx_size_reg > 8'd1)
                        begin
                            ack_next            = 1'b1;
                            master_rx_size_next = master_rx_size_reg - 8'd1;
                        end
                        else
                        begin
                            ack_next = 1'b0;
                        end
                    end
                    i2cts_pkg::EV_SLAR_NACK:
                    begin
                        stop_next      = 1'b1;
                        mode_busy_next = mode_busy_reg
                                       & ~(i2cts_pkg::BUSY_MT | i2cts_pkg::BUSY_MR);
                    end
                    i2cts_pkg::EV_MRX_ACK:
                    begin
                        act             = i2cts_pkg::ACT_MRX;
                        idx             = byte_index_reg;
                        stored          = item.rx_byte;
                        byte_index_next = index_inc;
                        ack_next        = (index_inc < master_rx_size_reg);
                    end
                    i2cts_pkg::EV_MRX_NACK:
                    begin
                        act            = i2cts_pkg::ACT_MRX;
                        idx            = byte_index_reg;
                        stored         = item.rx_byte;
                        ack_next       = slave_armed_reg;
                        stop_next      = 1'b1;
                        mode_busy_next = mode_busy_reg & ~i2cts_pkg::BUSY_MR;
                    end
                    i2cts_pkg::EV_OWN_SLAW, i2cts_pkg::EV_GCALL:
                    begin
                        byte_index_next = 8'd0;
                        ack_next        = (slave_rx_size_reg > 8'd1);
                    end
                    i2cts_pkg::EV_ARB_OWN_SLAW, i2cts_pkg::EV_ARB_GCALL:
                    begin
                        mode_busy_next  = mode_busy_reg
                                        & ~(i2cts_pkg::BUSY_MT | i2cts_pkg::BUSY_MR);
                        byte_index_next = 8'd0;
                        ack_next        = (slave_rx_size_reg > 8'd1);
                    end
                    i2cts_pkg::EV_SRX_ACK, i2cts_pkg::EV_GC_DATA_ACK:
                    begin
                        act             = i2cts_pkg::ACT_SRX;
                        idx             = byte_index_reg;
                        stored          = item.rx_byte;
                        byte_index_next = index_inc;
                        ack_next        = (index_inc < slave_rx_size_reg);
                    end
                    i2cts_pkg::EV_SRX_NACK, i2cts_pkg::EV_GC_DATA_NACK:
                    begin
                        act            = i2cts_pkg::ACT_SRX;
                        idx            = byte_index_reg;
                        stored         = item.rx_byte;
                        ack_next       = slave_armed_reg;
                        mode_busy_next = mode_busy_reg & ~i2cts_pkg::BUSY_SR;
                    end
                    i2cts_pkg::EV_SLAVE_STOP:
                    begin
                        ack_next       = slave_armed_reg;
                        mode_busy_next = mode_busy_reg & ~i2cts_pkg::BUSY_SR;
                    end
                    i2cts_pkg::EV_OWN_SLAR, i2cts_pkg::EV_ARB_OWN_SLAR:
                    begin
                        // addressed for read: index restarts, first byte goes out
                        if (item.bus_event == i2cts_pkg::EV_ARB_OWN_SLAR)
                        begin
                            mode_busy_next = mode_busy_reg
                                           & ~(i2cts_pkg::BUSY_MT | i2cts_pkg::BUSY_MR);
                        end
                        act             = i2cts_pkg::ACT_STX;
                        idx             = 8'd0;
                        byte_index_next = 8'd1;
                        ack_next        = (8'd1 < slave_tx_size_reg);
                    end
                    i2cts_pkg::EV_STX_ACK:
                    begin
                        act             = i2cts_pkg::ACT_STX;
                        idx             = byte_index_reg;
                        byte_index_next = index_inc;
                        ack_next        = (index_inc < slave_tx_size_reg);
                    end
                    i2cts_pkg::EV_STX_NACK, i2cts_pkg::EV_STX_LAST:
                    begin
                        mode_busy_next = mode_busy_reg & ~i2cts_pkg::BUSY_ST;
                        ack_next       = slave_armed_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg     <= 8'd0;
            addr_rw_byte_reg   <= 8'd0;
            master_tx_size_reg <= 8'd0;
            master_rx_size_reg <= 8'd0;
            slave_tx_size_reg  <= 8'd0;
            slave_rx_size_reg  <= 8'd0;
            mode_busy_reg      <= 4'd0;
            slave_armed_reg    <= 1'b0;
            start_reg          <= 1'b0;
            stop_reg           <= 1'b0;
            ack_reg            <= 1'b0;
        end
        else if (advance)
        begin
            byte_index_reg     <= byte_index_next;
            addr_rw_byte_reg   <= addr_rw_byte_next;
            master_tx_size_reg <= master_tx_size_next;
            master_rx_size_reg <= master_rx_size_next;
            slave_tx_size_reg  <= slave_tx_size_next;
            slave_rx_size_reg  <= slave_rx_size_next;
            mode_busy_reg      <= mode_busy_next;
            slave_armed_reg    <= slave_armed_next;
            start_reg          <= start_next;
            stop_reg           <= stop_next;
            ack_reg            <= ack_next;
        end
    end

    always_comb
    begin
        result.request_ok   = ok;
        result.start_bit    = start_next;
        result.stop_bit     = stop_next;
        result.ack_bit      = ack_next;
        result.byte_action  = act;
        result.address_byte = addr;
        result.buffer_index = idx;
        result.stored_byte  = stored;
        result.busy_flags   = mode_busy_next;
    end

endmodule

// File: rtl/core/i2cts_out_reg.sv
// Result register of the I2C transfer sequencer: holds one result beat until
// the receiver takes it. Depends on i2cts_pkg.
module i2cts_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  i2cts_pkg::result_t  result,
    output logic                space,
    i2cts_rsp_if.source         rsp
);

    logic                valid_reg;
    i2cts_pkg::result_t  data_reg;

    // free if empty or the held beat leaves this cycle
    assign space = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && space)
        begin
            data_reg <= result;
        end
    end

    assign rsp.valid        = valid_reg;
    assign rsp.request_ok   = data_reg.request_ok;
    assign rsp.start_bit    = data_reg.start_bit;
    assign rsp.stop_bit     = data_reg.stop_bit;
    assign rsp.ack_bit      = data_reg.ack_bit;
    assign rsp.byte_action  = data_reg.byte_action;
    assign rsp.address_byte = data_reg.address_byte;
    assign rsp.buffer_index = data_reg.buffer_index;
    assign rsp.stored_byte  = data_reg.stored_byte;
    assign rsp.busy_flags   = data_reg.busy_flags;

endmodule

// File: rtl/core/i2c_transfer_sequencer.sv
// I2C transfer sequencer top level: input item register, decision engine and
// result register. Depends on i2cts_pkg, i2cts_if, i2cts_engine, i2cts_out_reg.
//
// Usage:
//   req carries one item per beat: a request (master write/read, slave
//   transmit/receive, stop) or a bus status event with the received byte.
//   rsp carries one result beat per item: request_ok, start/stop/ack control
//   bits, byte action with address byte or buffer index and stored byte, and
//   the busy flags, all as they stand after the item.
// Path: an item taken from req sits in the input register, is decided and
//   lands in the result register, and is offered on rsp from there.
// Throughput: one item per cycle while rsp.ready stays high. The decision is
//   a single pass through the engine between the two registers; sequencer
//   state commits in the same edge that loads the result register.
// Reset: all sequencer state, control bits and busy flags clear; both
//   registers empty. Items held in either register are dropped by reset.
// Stall: while rsp.ready is low the result register holds its beat; one more
//   item can still be taken into the input register, after which req.ready
//   drops until the result beat is taken.
module i2c_transfer_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    i2cts_req_if.sink   req,
    i2cts_rsp_if.source rsp
);

    logic                in_valid_reg;
    i2cts_pkg::item_t    in_item_reg;
    logic                space;
    logic                advance;
    i2cts_pkg::result_t  result;

    assign advance   = in_valid_reg && space;
    assign req.ready = !in_valid_reg || space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_item_reg.operation     <= req.operation;
            in_item_reg.bus_event     <= req.bus_event;
            in_item_reg.slave_address <= req.slave_address;
            in_item_reg.byte_count    <= req.byte_count;
            in_item_reg.rx_byte       <= req.rx_byte;
        end
    end

    i2cts_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    i2cts_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .result (result),
        .space  (space),
        .rsp    (rsp)
    );

endmodule

// File: rtl/core/i2cts_checker.sv
// Port-level checks for the I2C transfer sequencer, bound to the top level.
// Depends on i2cts_pkg and i2c_transfer_sequencer.
module i2cts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       request_ok,
    input logic [2:0] byte_action,
    input logic [7:0] address_byte,
    input logic [7:0] buffer_index,
    input logic [7:0] stored_byte
);

    // held result beat does not change while stalled
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(byte_action)
            && $stable(buffer_index) && $stable(stored_byte))
        else $error("result beat changed while stalled");

    a_addr_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && byte_action != i2cts_pkg::ACT_ADDR |-> address_byte == 8'd0)
        else $error("address byte set without address action");

    a_stored_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && byte_action != i2cts_pkg::ACT_MRX
            && byte_action != i2cts_pkg::ACT_SRX |-> stored_byte == 8'd0)
        else $error("stored byte set without receive action");

    a_index_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (byte_action == i2cts_pkg::ACT_NONE
            || byte_action == i2cts_pkg::ACT_ADDR) |-> buffer_index == 8'd0)
        else $error("buffer index set without buffer action");

    a_request_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && request_ok |-> byte_action == i2cts_pkg::ACT_NONE)
        else $error("accepted request carries a byte action");

endmodule

bind i2c_transfer_sequencer i2cts_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .request_ok   (rsp.request_ok),
    .byte_action  (rsp.byte_action),
    .address_byte (rsp.address_byte),
    .buffer_index (rsp.buffer_index),
    .stored_byte  (rsp.stored_byte)
);

// File: tb/tb_i2c_transfer_sequencer.sv
`timescale 1ns / 100ps
// Self-checking bench for i2c_transfer_sequencer: directed and random request/bus event
// beats, a predictor class that checks every result beat in order.
// Depends on i2cts_pkg, i2cts_if and the RTL of the block.
module tb_i2c_transfer_sequencer;
    import i2cts_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 80;

    // Predicts the sequencer's result for each accepted item and keeps them in order.
    class result_scoreboard;
        logic [7:0] byte_index;
        logic [7:0] addr_rw_byte;
        logic [7:0] mtx_size;
        logic [7:0] mrx_size;
        logic [7:0] stx_size;
        logic [7:0] srx_size;
        logic [3:0] busy;
        logic       slave_armed;
        logic       start_b;
        logic       stop_b;
        logic       ack_b;
        result_t    expected_q[$];
        int         errors;

        function new();
            byte_index   = '0;
            addr_rw_byte = '0;
            mtx_size     = '0;
            mrx_size     = '0;
            stx_size     = '0;
            srx_size     = '0;
            busy         = '0;
            slave_armed  = 1'b0;
            start_b      = 1'b0;
            stop_b       = 1'b0;
            ack_b        = 1'b0;
            errors       = 0;
        endfunction

        function void load_slave_tx(inout result_t r);
            r.byte_action  = ACT_STX;
            r.buffer_index = byte_index;
            byte_index     = byte_index + 8'd1;
            ack_b          = (byte_index < stx_size);
        endfunction

        function void slave_write_addressed();
            byte_index = '0;
            ack_b      = (srx_size > 8'd1);
        endfunction

        function result_t predict(item_t it);
            result_t r;
            r = '0;
            case (it.operation)
                OP_MASTER_WRITE, OP_MASTER_READ:
                begin
                    if ((busy & (BUSY_MT | BUSY_MR)) == 4'b0)
                    begin
                        if (it.operation == OP_MASTER_WRITE)
                        begin
                            busy         |= BUSY_MT;
                            mtx_size      = it.byte_count;
                            addr_rw_byte  = {it.slave_address, RW_WRITE};
                        end
                        else
                        begin
                            busy         |= BUSY_MR;
                            mrx_size      = it.byte_count;
                            addr_rw_byte  = {it.slave_address, RW_READ};
                        end
                        stop_b       = 1'b0;
                        start_b      = 1'b1;
                        r.request_ok = 1'b1;
                    end
                end
                OP_SLAVE_TX:
                begin
                    if ((busy & BUSY_ST) == 4'b0)
                    begin
                        busy        |= BUSY_ST;
                        slave_armed  = 1'b1;
                        stx_size     = it.byte_count;
                        ack_b        = 1'b1;
                        r.request_ok = 1'b1;
                    end
                end
                OP_SLAVE_RX:
                begin
                    if ((busy & BUSY_SR) == 4'b0)
                    begin
                        busy        |= BUSY_SR;
                        slave_armed  = 1'b1;
                        srx_size     = it.byte_count;
                        ack_b        = 1'b1;
                        r.request_ok = 1'b1;
                    end
                end
                OP_STOP:
                begin
                    stop_b       = 1'b1;
                    r.request_ok = 1'b1;
                end
                OP_BUS_EVENT:
                begin
                    case (it.bus_event)
                        EV_BUS_ERROR:
                        begin
                            start_b = 1'b0;
                            stop_b  = 1'b1;
                            ack_b   = 1'b0;
                        end
                        EV_START, EV_REP_START:
                        begin
                            byte_index     = '0;
                            r.byte_action  = ACT_ADDR;
                            r.address_byte = addr_rw_byte;
                            start_b        = 1'b0;
                        end
                        EV_SLAW_ACK:
                        begin
                            r.byte_action  = ACT_MTX;
                            r.buffer_index = byte_index;
                        end
                        EV_MTX_ACK:
                        begin
                            byte_index = byte_index + 8'd1;
                            if (byte_index < mtx_size)
                            begin
                                r.byte_action  = ACT_MTX;
                                r.buffer_index = byte_index;
                            end
                            else
                            begin
                                stop_b  = 1'b1;
                                busy   &= ~BUSY_MT;
                            end
                        end
                        EV_SLAW_NACK, EV_MTX_NACK:
                        begin
                            stop_b  = 1'b1;
                            busy   &= ~BUSY_MT;
                        end
                        EV_ARB_LOST:
                            busy &= ~BUSY_MT;
                        EV_SLAR_ACK:
                        begin
                            // single-byte read NACKs its only byte
                            if (mrx_size > 8'd1)
                            begin
                                ack_b    = 1'b1;
                                mrx_size = mrx_size - 8'd1;
                            end
                            else
                                ack_b = 1'b0;
                        end
                        EV_SLAR_NACK:
                        begin
                            stop_b  = 1'b1;
                            busy   &= ~(BUSY_MT | BUSY_MR);
                        end
                        EV_MRX_ACK:
                        begin
                            r.byte_action  = ACT_MRX;
                            r.buffer_index = byte_index;
                            r.stored_byte  = it.rx_byte;
                            byte_index     = byte_index + 8'd1;
                            ack_b          = (byte_index < mrx_size);
                        end
                        EV_MRX_NACK:
                        begin
                            r.byte_action  = ACT_MRX;
                            r.buffer_index = byte_index;
                            r.stored_byte  = it.rx_byte;
                            ack_b          = slave_armed;
                            stop_b         = 1'b1;
                            busy          &= ~BUSY_MR;
                        end
                        EV_OWN_SLAW, EV_GCALL:
                            slave_write_addressed();
                        EV_ARB_OWN_SLAW, EV_ARB_GCALL:
                        begin
                            busy &= ~(BUSY_MT | BUSY_MR);
                            slave_write_addressed();
                        end
                        EV_SRX_ACK, EV_GC_DATA_ACK:
                        begin
                            r.byte_action  = ACT_SRX;
                            r.buffer_index = byte_index;
                            r.stored_byte  = it.rx_byte;
                            byte_index     = byte_index + 8'd1;
                            ack_b          = (byte_index < srx_size);
                        end
                        EV_SRX_NACK, EV_GC_DATA_NACK:
                        begin
                            r.byte_action  = ACT_SRX;
                            r.buffer_index = byte_index;
                            r.stored_byte  = it.rx_byte;
                            ack_b          = slave_armed;
                            busy          &= ~BUSY_SR;
                        end
                        EV_SLAVE_STOP:
                        begin
                            ack_b  = slave_armed;
                            busy  &= ~BUSY_SR;
                        end
                        EV_ARB_OWN_SLAR:
                        begin
                            busy       &= ~(BUSY_MT | BUSY_MR);
                            byte_index  = '0;
                            load_slave_tx(r);
                        end
                        EV_OWN_SLAR:
                        begin
                            byte_index = '0;
                            load_slave_tx(r);
                        end
                        EV_STX_ACK:
                            load_slave_tx(r);
                        EV_STX_NACK, EV_STX_LAST:
                        begin
                            busy  &= ~BUSY_ST;
                            ack_b  = slave_armed;
                        end
                        default:
                            ;   // no relevant state, codes past the table included
                    endcase
                end
                default:
                    ;   // undefined operation codes leave everything alone
            endcase
            r.start_bit  = start_b;
            r.stop_bit   = stop_b;
            r.ack_bit    = ack_b;
            r.busy_flags = busy;
            return r;
        endfunction

        function void note_item(item_t it);
            expected_q.push_back(predict(it));
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected, actual %h", $time, got);
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("request_ok",   8'(exp_r.request_ok),  8'(got.request_ok));
            compare_field("start_bit",    8'(exp_r.start_bit),   8'(got.start_bit));
            compare_field("stop_bit",     8'(exp_r.stop_bit),    8'(got.stop_bit));
            compare_field("ack_bit",      8'(exp_r.ack_bit),     8'(got.ack_bit));
            compare_field("byte_action",  8'(exp_r.byte_action), 8'(got.byte_action));
            compare_field("address_byte", exp_r.address_byte, got.address_byte);
            compare_field("buffer_index", exp_r.buffer_index, got.buffer_index);
            compare_field("stored_byte",  exp_r.stored_byte,  got.stored_byte);
            compare_field("busy_flags",   8'(exp_r.busy_flags),  8'(got.busy_flags));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic hold_rsp;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   phase;
    int   items_sent;

    result_scoreboard sb;

    i2cts_req_if req_ch ();
    i2cts_rsp_if rsp_ch ();

    i2c_transfer_sequencer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic item_t mk_item(logic [2:0] op, logic [4:0] ev, logic [6:0] sa,
                                      logic [7:0] cnt, logic [7:0] rx);
        item_t it;
        it.operation     = op;
        it.bus_event     = ev;
        it.slave_address = sa;
        it.byte_count    = cnt;
        it.rx_byte       = rx;
        return it;
    endfunction

    task automatic send_item(item_t it);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= it.operation;
        req_ch.bus_event     <= it.bus_event;
        req_ch.slave_address <= it.slave_address;
        req_ch.byte_count    <= it.byte_count;
        req_ch.rx_byte       <= it.rx_byte;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic send_event(bus_event_t ev);
        send_item(mk_item(OP_BUS_EVENT, ev, 7'($urandom), 8'($urandom), 8'($urandom)));
    endtask

    task automatic send_event_rx(bus_event_t ev, logic [7:0] rx);
        send_item(mk_item(OP_BUS_EVENT, ev, 7'($urandom), 8'($urandom), rx));
    endtask

    task automatic send_request(op_t op, logic [6:0] sa, logic [7:0] cnt);
        send_item(mk_item(op, 5'($urandom), sa, cnt, 8'($urandom)));
    endtask

    // mostly short transfers, now and then any size
    function automatic logic [7:0] pick_count();
        if ($urandom_range(0, 9) < 8)
            return 8'($urandom_range(0, 6));
        return 8'($urandom);
    endfunction

    function automatic int data_beats(logic [7:0] n);
        return ((n > 8) ? 8 : int'(n)) + $urandom_range(0, 1);
    endfunction

    task automatic master_write_seq();
        logic [7:0] n;
        n = pick_count();
        send_request(OP_MASTER_WRITE, 7'($urandom), n);
        send_event($urandom_range(0, 1) ? EV_START : EV_REP_START);
        if ($urandom_range(0, 7) == 0)
        begin
            send_event($urandom_range(0, 1) ? EV_SLAW_NACK : EV_ARB_LOST);
            return;
        end
        send_event(EV_SLAW_ACK);
        repeat (data_beats(n)) send_event(EV_MTX_ACK);
        if ($urandom_range(0, 3) == 0)
            send_event(EV_MTX_NACK);
        send_request(OP_STOP, 7'($urandom), 8'($urandom));
    endtask

    task automatic master_read_seq();
        logic [7:0] n;
        n = pick_count();
        send_request(OP_MASTER_READ, 7'($urandom), n);
        send_event($urandom_range(0, 1) ? EV_START : EV_REP_START);
        if ($urandom_range(0, 7) == 0)
        begin
            send_event(EV_SLAR_NACK);
            return;
        end
        send_event(EV_SLAR_ACK);
        repeat (data_beats(n)) send_event_rx(EV_MRX_ACK, 8'($urandom));
        send_event_rx(EV_MRX_NACK, 8'($urandom));
        send_request(OP_STOP, 7'($urandom), 8'($urandom));
    endtask

    task automatic slave_rx_seq();
        logic [7:0] n;
        logic       gcall;
        n     = pick_count();
        gcall = $urandom_range(0, 3) == 0;
        send_request(OP_SLAVE_RX, 7'($urandom), n);
        case ($urandom_range(0, 3))
            0: send_event(EV_OWN_SLAW);
            1: send_event(EV_ARB_OWN_SLAW);
            2: send_event(EV_GCALL);
            default: send_event(EV_ARB_GCALL);
        endcase
        repeat (data_beats(n))
            send_event_rx(gcall ? EV_GC_DATA_ACK : EV_SRX_ACK, 8'($urandom));
        if ($urandom_range(0, 1))
            send_event_rx(gcall ? EV_GC_DATA_NACK : EV_SRX_NACK, 8'($urandom));
        send_event(EV_SLAVE_STOP);
    endtask

    task automatic slave_tx_seq();
        logic [7:0] n;
        n = pick_count();
        send_request(OP_SLAVE_TX, 7'($urandom), n);
        send_event($urandom_range(0, 1) ? EV_OWN_SLAR : EV_ARB_OWN_SLAR);
        repeat (data_beats(n)) send_event(EV_STX_ACK);
        send_event($urandom_range(0, 1) ? EV_STX_NACK : EV_STX_LAST);
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 4))
            send_item(mk_item(3'($urandom), 5'($urandom), 7'($urandom), 8'($urandom),
                              8'($urandom)));
    endtask

    task automatic random_traffic(int target);
        int first;
        first = items_sent;
        while (items_sent - first < target)
        begin
            case ($urandom_range(0, 9))
                0, 1: master_write_seq();
                2, 3: master_read_seq();
                4, 5: slave_rx_seq();
                6, 7: slave_tx_seq();
                default: noise_burst();
            endcase
        end
    endtask

    task automatic directed_part();
        // undefined operations and event codes past the table
        send_item(mk_item(3'd6, 5'h1F, 7'h7F, 8'hFF, 8'hFF));
        send_item(mk_item(3'd7, 5'h00, 7'h00, 8'h00, 8'h00));
        send_item(mk_item(OP_BUS_EVENT, 5'd31, 7'h7F, 8'hFF, 8'hFF));
        send_event(EV_NONE);
        // one-byte master read; a second master request is refused while busy
        send_request(OP_MASTER_READ, 7'h7F, 8'd1);
        send_request(OP_MASTER_WRITE, 7'h00, 8'hFF);
        send_event(EV_START);
        send_event(EV_SLAR_ACK);
        send_event_rx(EV_MRX_NACK, 8'hFF);
        send_request(OP_STOP, 7'h00, 8'h00);
        send_request(OP_MASTER_READ, 7'h2A, 8'd3);
        send_event(EV_REP_START);
        send_event(EV_SLAR_ACK);
        send_event_rx(EV_MRX_ACK, 8'h00);
        send_event_rx(EV_MRX_NACK, 8'hA5);
        // zero-length write ends on the first data ack
        send_request(OP_MASTER_WRITE, 7'h55, 8'd0);
        send_event(EV_START);
        send_event(EV_SLAW_ACK);
        send_event(EV_MTX_ACK);
        // slave receive refused only while slave receive is busy
        send_request(OP_SLAVE_RX, 7'h00, 8'd0);
        send_request(OP_SLAVE_RX, 7'h7F, 8'hFF);
        send_event(EV_OWN_SLAW);
        send_event(EV_SLAVE_STOP);
        send_request(OP_SLAVE_TX, 7'h7F, 8'hFF);
        send_event(EV_OWN_SLAR);
        send_event(EV_STX_LAST);
        send_event(EV_BUS_ERROR);
        send_event(EV_ARB_LOST);
    endtask

    // long slave receive so the byte index wraps past 255
    task automatic index_wrap_seq();
        send_request(OP_SLAVE_RX, 7'($urandom), 8'd200);
        send_event(EV_OWN_SLAW);
        repeat (258) send_event_rx(EV_SRX_ACK, 8'($urandom));
        send_event(EV_SLAVE_STOP);
    endtask

    // result side: check each beat, then pick ready for the next cycle
    initial
    begin
        result_t got;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.request_ok   = rsp_ch.request_ok;
                got.start_bit    = rsp_ch.start_bit;
                got.stop_bit     = rsp_ch.stop_bit;
                got.ack_bit      = rsp_ch.ack_bit;
                got.byte_action  = rsp_ch.byte_action;
                got.address_byte = rsp_ch.address_byte;
                got.buffer_index = rsp_ch.buffer_index;
                got.stored_byte  = rsp_ch.stored_byte;
                got.busy_flags   = rsp_ch.busy_flags;
                sb.check_result(got);
            end
            rsp_ch.ready <= !hold_rsp && ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // back-pressure burst: result side stalls while items keep coming
    initial
    begin
        hold_rsp = 1'b0;
        wait (phase == 3);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        sb                   = new();
        phase                = 0;
        items_sent           = 0;
        src_idle_pct         = 17;
        sink_idle_pct        = 73;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.operation     = '0;
        req_ch.bus_event     = '0;
        req_ch.slave_address = '0;
        req_ch.byte_count    = '0;
        req_ch.rx_byte       = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        phase = 1;
        directed_part();
        random_traffic(150);

        phase         = 2;
        src_idle_pct  = 73;
        sink_idle_pct = 17;
        random_traffic(150);

        phase         = 3;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        index_wrap_seq();
        random_traffic(100);

        req_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
